[design/assert_macros.svh]
// Assertion macros shared by the memo table design.
// Included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked each clock, disabled in reset
`define ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication checked each clock, disabled in reset
`define ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

[design/hmt_pkg.sv]
// Package for the hashed memo table: sizes, hash constants, helper types.
// No dependencies.
`timescale 1ns / 1ps
package hmt_pkg;
  localparam int ShardCount    = 4;
  localparam int SlotsPerShard = 256;
  localparam int TotalSlots    = ShardCount * SlotsPerShard;
  localparam int IdxW          = $clog2(TotalSlots);
  localparam int ShardW        = (ShardCount > 1) ? $clog2(ShardCount) : 1;
  localparam int SlotW         = (SlotsPerShard > 1) ? $clog2(SlotsPerShard) : 1;
  localparam int KeyW          = 63;
  localparam int BoundW        = 32;
  localparam int DepthW        = 3;
  localparam int MetaW         = 5;
  localparam int EntW          = 11;
  localparam int CntW          = 32;
  localparam int MaxHitDepth   = 4;
  localparam int EntryW        = 1 + KeyW + BoundW + MetaW;

  localparam logic [63:0] Mul1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] Mul2 = 64'h94d049bb133111eb;
  localparam logic [EntW-1:0] EntryMax = 11'd2047;
  localparam logic [CntW-1:0] CntMax = '1;

  typedef enum logic [0:0] {
    FUNC_LOOKUP = 1'b0,
    FUNC_STORE  = 1'b1
  } func_t;

  typedef struct packed {
    logic              vld;
    logic [KeyW-1:0]   key;
    logic [BoundW-1:0] bound;
    logic [MetaW-1:0]  meta;
  } entry_t;
endpackage

[design/hmt_if.sv]
// Valid/ready channel interfaces for input and result words.
// Depends on hmt_pkg.
`timescale 1ns / 1ps
interface hmt_in_if import hmt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                func;
  logic [KeyW-1:0]     key_prefix;
  logic [DepthW-1:0]   req_depth;
  logic [BoundW-1:0]   entry_bound;
  logic                entry_proof;
  logic                entry_complete;
  modport source (output valid, func, key_prefix, req_depth, entry_bound, entry_proof,
                  entry_complete, input ready);
  modport sink (input valid, func, key_prefix, req_depth, entry_bound, entry_proof,
                entry_complete, output ready);
endinterface

interface hmt_out_if import hmt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [BoundW-1:0] found_bound;
  logic [DepthW-1:0] found_depth;
  logic              found_proof;
  logic              collided;
  logic [EntW-1:0]   entries_total;
  logic [CntW-1:0]   collisions_total;
  logic [CntW-1:0]   saturations_total;
  logic [CntW-1:0]   hits_at_depth;
  modport source (output valid, hit, found_bound, found_depth, found_proof, collided,
                  entries_total, collisions_total, saturations_total, hits_at_depth,
                  input ready);
  modport sink (input valid, hit, found_bound, found_depth, found_proof, collided,
                entries_total, collisions_total, saturations_total, hits_at_depth,
                output ready);
endinterface

[design/hmt_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module hmt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[design/hmt_hash.sv]
// Splitmix64 finaliser, five register stages, multiplies split into 32-bit products.
// Depends on hmt_pkg.
`timescale 1ns / 1ps
module hmt_hash import hmt_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] x_in,
  output logic [63:0] h_out
);
  logic [63:0] x0_r;
  logic [63:0] pa_r, pb_r, pc_r;
  logic [63:0] y_r;
  logic [63:0] qa_r, qb_r, qc_r;
  logic [63:0] s1, z1;

  // 64x64 low half: a_lo*b_lo + ((a_lo*b_hi + a_hi*b_lo) << 32)
  assign s1 = pa_r + {pb_r[31:0] + pc_r[31:0], 32'd0};
  assign z1 = qa_r + {qb_r[31:0] + qc_r[31:0], 32'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r  <= x_in ^ (x_in >> 30);
      pa_r  <= x0_r[31:0] * Mul1[31:0];
      pb_r  <= {32'd0, x0_r[31:0] * Mul1[63:32]};
      pc_r  <= {32'd0, x0_r[63:32] * Mul1[31:0]};
      y_r   <= s1 ^ (s1 >> 27);
      qa_r  <= y_r[31:0] * Mul2[31:0];
      qb_r  <= {32'd0, y_r[31:0] * Mul2[63:32]};
      qc_r  <= {32'd0, y_r[63:32] * Mul2[31:0]};
      h_out <= z1 ^ (z1 >> 31);
    end
  end
endmodule

[design/hashed_memo_table_top.sv]
// Hashed memo table top: hash pipeline, table RAM read-modify-write, counters.
// Depends on hmt_pkg, hmt_if, hmt_ram, hmt_hash, assert_macros.svh.
// Channel | Port prefix | Word
// input   | in_         | func, key, depth, bound, proof, complete
// result  | out_        | hit, found fields, collided, four totals
// After reset a clearing pass over all 1024 slots marks every slot empty; in_ready is low.
// One word at a time: hash, RAM read, update, result and idle states in that order,
// and the result state holds while out_ready is low; no new word until back in idle.
// in_ready is low from acceptance until the result word is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hashed_memo_table_top import hmt_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  hmt_in_if.sink    in_ch,
  hmt_out_if.source out_ch
);
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_HASH = 6'b000010,
    ST_READ = 6'b000100,
    ST_UPD  = 6'b001000,
    ST_OUT  = 6'b010000,
    ST_CLR  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [IdxW-1:0] clr_r, clr_nxt;
  logic func_r;
  logic [KeyW-1:0] key_r;
  logic [DepthW-1:0] depth_r;
  logic [BoundW-1:0] bound_r;
  logic proof_r, comp_r;
  logic [63:0] h;
  logic [IdxW-1:0] idx_r;
  logic [IdxW-1:0] waddr;
  entry_t rd;
  logic [EntryW-1:0] rdata, wdata;
  logic we;
  logic [EntW-1:0] ent_r;
  logic [CntW-1:0] col_r, sat_r;
  logic [CntW-1:0] dh_r [MaxHitDepth+1];
  logic hit_r, colo_r;
  logic [BoundW-1:0] fb_r;
  logic [DepthW-1:0] fd_r;
  logic fp_r;
  logic [CntW-1:0] had_r;
  logic same, dok, do_hit, do_col, replace;
  logic [IdxW-1:0] idx_c;
  logic [CntW-1:0] col_n, dh_n;

  hmt_hash u_hash (
    .clk  (clk),
    .en   (1'b1),
    .x_in ({1'b0, key_r}),
    .h_out(h)
  );

  assign idx_c = IdxW'((h % 64'(ShardCount)) * 64'(SlotsPerShard) + (h % 64'(SlotsPerShard)));

  hmt_ram #(.Width(EntryW), .Depth(TotalSlots)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(idx_r),
    .rdata(rdata)
  );

  assign rd = rdata;
  assign same = rd.vld && (rd.key == key_r);
  assign dok = (depth_r <= DepthW'(MaxHitDepth));
  assign do_col = rd.vld && !same && (func_r == FUNC_STORE || dok);
  assign do_hit = (func_r == FUNC_LOOKUP) && dok && same && rd.meta[4]
                  && (rd.meta[2:0] == depth_r);
  assign replace = !rd.vld || !same || (depth_r >= rd.meta[2:0]) || (bound_r > rd.bound);
  assign we = (state_r == ST_CLR) ||
              ((state_r == ST_UPD) && (func_r == FUNC_STORE) && replace);
  assign waddr = (state_r == ST_CLR) ? clr_r : idx_r;
  assign wdata = (state_r == ST_CLR) ? '0 : {1'b1, key_r, bound_r, comp_r, proof_r, depth_r};
  assign col_n = (do_col && col_r != CntMax) ? col_r + 1'b1 : col_r;
  assign dh_n = dok ? dh_r[depth_r] : '0;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid = (state_r == ST_OUT);
  assign out_ch.hit = hit_r;
  assign out_ch.found_bound = fb_r;
  assign out_ch.found_depth = fd_r;
  assign out_ch.found_proof = fp_r;
  assign out_ch.collided = colo_r;
  assign out_ch.entries_total = ent_r;
  assign out_ch.collisions_total = col_r;
  assign out_ch.saturations_total = sat_r;
  assign out_ch.hits_at_depth = had_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    clr_nxt = clr_r;
    case (state_r)
      ST_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == IdxW'(TotalSlots - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: if (in_ch.valid) begin
        state_nxt = ST_HASH;
        cnt_nxt = '0;
      end
      ST_HASH: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd5) state_nxt = ST_READ;
      end
      ST_READ: state_nxt = ST_UPD;
      ST_UPD: state_nxt = ST_OUT;
      ST_OUT: if (out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      cnt_r <= '0;
      clr_r <= '0;
      ent_r <= '0;
      col_r <= '0;
      sat_r <= '0;
      for (int i = 0; i <= MaxHitDepth; i++) dh_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      clr_r <= clr_nxt;
      if (state_r == ST_UPD) begin
        col_r <= col_n;
        if (func_r == FUNC_STORE) begin
          if (do_col && sat_r != CntMax) sat_r <= sat_r + 1'b1;
          if (!rd.vld && ent_r != EntryMax) ent_r <= ent_r + 1'b1;
        end
        if (do_hit && dh_r[depth_r] != CntMax) dh_r[depth_r] <= dh_r[depth_r] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_ch.valid) begin
      func_r <= in_ch.func;
      key_r <= in_ch.key_prefix;
      depth_r <= in_ch.req_depth;
      bound_r <= in_ch.entry_bound;
      proof_r <= in_ch.entry_proof;
      comp_r <= in_ch.entry_complete;
    end
    if (state_r == ST_HASH) idx_r <= idx_c;
    if (state_r == ST_UPD) begin
      hit_r <= do_hit;
      fb_r <= do_hit ? rd.bound : '0;
      fd_r <= do_hit ? rd.meta[2:0] : '0;
      fp_r <= do_hit ? rd.meta[3] : 1'b0;
      colo_r <= do_col;
      had_r <= (do_hit && dh_n != CntMax) ? dh_n + 1'b1 : dh_n;
    end
  end

  `ASSERT_IMP(a_ready_idle, clk, rst_n, in_ch.ready, !out_ch.valid)
  `ASSERT_NXT(a_accept_busy, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  `ASSERT_IMP(a_hit_clean, clk, rst_n, out_ch.valid && !out_ch.hit,
              out_ch.found_bound == '0 && out_ch.found_depth == '0)
endmodule

[test/tb.sv]
// Testbench for hashed_memo_table_top: directed and random lookups and stores,
// checked word by word against an in-bench model of the table and counters.
// Depends on hmt_pkg, hmt_if and the design files.
`timescale 1ns / 1ps
module tb;
  import hmt_pkg::*;

  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic              hit;
    logic [BoundW-1:0] found_bound;
    logic [DepthW-1:0] found_depth;
    logic              found_proof;
    logic              collided;
    logic [EntW-1:0]   entries_total;
    logic [CntW-1:0]   collisions_total;
    logic [CntW-1:0]   saturations_total;
    logic [CntW-1:0]   hits_at_depth;
  } memo_word_t;

  logic clk;
  logic rst_n;
  hmt_in_if  in_ch ();
  hmt_out_if out_ch ();

  hashed_memo_table_top u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // model state
  bit                tbl_valid[TotalSlots];
  logic [KeyW-1:0]   tbl_key[TotalSlots];
  logic [BoundW-1:0] tbl_bound[TotalSlots];
  logic [MetaW-1:0]  tbl_meta[TotalSlots];
  logic [EntW-1:0]   fill_cnt;
  logic [CntW-1:0]   coll_cnt;
  logic [CntW-1:0]   disp_cnt;
  logic [CntW-1:0]   depth_hits[MaxHitDepth+1];

  memo_word_t      pending_q[$];
  logic [KeyW-1:0] key_pool[$];
  bit              failed;
  bit              quiet;
  int              hold_cycles;
  int              cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] splitmix(logic [63:0] x);
    x = x ^ (x >> 30);
    x = x * Mul1;
    x = x ^ (x >> 27);
    x = x * Mul2;
    return x ^ (x >> 31);
  endfunction

  function automatic int slot_of(logic [KeyW-1:0] key);
    logic [63:0] h;
    h = splitmix({1'b0, key});
    return int'(h % ShardCount) * SlotsPerShard + int'(h % SlotsPerShard);
  endfunction

  function automatic logic [CntW-1:0] bump(logic [CntW-1:0] v);
    return (v == CntMax) ? v : v + 1'b1;
  endfunction

  function automatic logic [KeyW-1:0] rand_key();
    return KeyW'({$urandom(), $urandom()});
  endfunction

  function automatic logic [KeyW-1:0] rival_key(logic [KeyW-1:0] key);
    logic [KeyW-1:0] k;
    int target;
    target = slot_of(key);
    do k = rand_key(); while (k == key || slot_of(k) != target);
    return k;
  endfunction

  function automatic memo_word_t predict_memo(func_t f, logic [KeyW-1:0] key,
      logic [DepthW-1:0] d, logic [BoundW-1:0] b, logic p, logic c);
    memo_word_t r;
    int i;
    bit v, same;
    r = '0;
    i = slot_of(key);
    v = tbl_valid[i];
    same = v && tbl_key[i] == key;
    if (f == FUNC_LOOKUP) begin
      if (d <= MaxHitDepth && v) begin
        if (!same) begin
          r.collided = 1'b1;
          coll_cnt = bump(coll_cnt);
        end else if (tbl_meta[i][4] && tbl_meta[i][2:0] == d) begin
          r.hit = 1'b1;
          r.found_bound = tbl_bound[i];
          r.found_depth = tbl_meta[i][2:0];
          r.found_proof = tbl_meta[i][3];
          depth_hits[d] = bump(depth_hits[d]);
        end
      end
    end else begin
      if (v && !same) begin
        r.collided = 1'b1;
        coll_cnt = bump(coll_cnt);
        disp_cnt = bump(disp_cnt);
      end
      if (!v && fill_cnt < EntryMax) fill_cnt = fill_cnt + 1'b1;
      if (!v || !same || d >= tbl_meta[i][2:0] || b > tbl_bound[i]) begin
        tbl_key[i] = key;
        tbl_bound[i] = b;
        tbl_meta[i] = {c, p, d};
        tbl_valid[i] = 1'b1;
      end
    end
    r.entries_total = fill_cnt;
    r.collisions_total = coll_cnt;
    r.saturations_total = disp_cnt;
    r.hits_at_depth = (d <= MaxHitDepth) ? depth_hits[d] : '0;
    return r;
  endfunction

  // accepted input words feed the model
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      pending_q.insert(pending_q.size(), predict_memo(func_t'(in_ch.func),
          in_ch.key_prefix, in_ch.req_depth, in_ch.entry_bound, in_ch.entry_proof,
          in_ch.entry_complete));
  end

  // result words against the oldest expectation
  always @(posedge clk) begin
    memo_word_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        $error("result word with nothing expected");
        failed = 1'b1;
      end else begin
        e = pending_q.pop_front();
        if (out_ch.hit !== e.hit) begin
          $error("hit exp %0h got %0h", e.hit, out_ch.hit); failed = 1'b1;
        end
        if (out_ch.found_bound !== e.found_bound) begin
          $error("found_bound exp %0h got %0h", e.found_bound, out_ch.found_bound);
          failed = 1'b1;
        end
        if (out_ch.found_depth !== e.found_depth) begin
          $error("found_depth exp %0h got %0h", e.found_depth, out_ch.found_depth);
          failed = 1'b1;
        end
        if (out_ch.found_proof !== e.found_proof) begin
          $error("found_proof exp %0h got %0h", e.found_proof, out_ch.found_proof);
          failed = 1'b1;
        end
        if (out_ch.collided !== e.collided) begin
          $error("collided exp %0h got %0h", e.collided, out_ch.collided); failed = 1'b1;
        end
        if (out_ch.entries_total !== e.entries_total) begin
          $error("entries_total exp %0h got %0h", e.entries_total, out_ch.entries_total);
          failed = 1'b1;
        end
        if (out_ch.collisions_total !== e.collisions_total) begin
          $error("collisions_total exp %0h got %0h", e.collisions_total,
                 out_ch.collisions_total);
          failed = 1'b1;
        end
        if (out_ch.saturations_total !== e.saturations_total) begin
          $error("saturations_total exp %0h got %0h", e.saturations_total,
                 out_ch.saturations_total);
          failed = 1'b1;
        end
        if (out_ch.hits_at_depth !== e.hits_at_depth) begin
          $error("hits_at_depth exp %0h got %0h", e.hits_at_depth, out_ch.hits_at_depth);
          failed = 1'b1;
        end
      end
    end
  end

  // receiver: random stalls, or a counted hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ch.ready <= quiet || ($urandom_range(0, 99) >= 15);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_word(func_t f, logic [KeyW-1:0] key, logic [DepthW-1:0] d,
      logic [BoundW-1:0] b, logic p, logic c);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.key_prefix <= key;
    in_ch.req_depth <= d;
    in_ch.entry_bound <= b;
    in_ch.entry_proof <= p;
    in_ch.entry_complete <= c;
    forever begin
      @(negedge clk);
      if (in_ch.ready) break;
    end
    @(posedge clk);
    gap = (!quiet && $urandom_range(0, 99) < 15) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [KeyW-1:0] kmax, krival;
    kmax = '1;
    send_word(FUNC_LOOKUP, '0, 3'd0, '0, 1'b0, 1'b0);
    send_word(FUNC_STORE, '0, 3'd0, '0, 1'b0, 1'b1);
    send_word(FUNC_LOOKUP, '0, 3'd0, '1, 1'b1, 1'b1);
    send_word(FUNC_STORE, kmax, 3'd4, '1, 1'b1, 1'b1);
    send_word(FUNC_LOOKUP, kmax, 3'd4, '0, 1'b0, 1'b0);
    send_word(FUNC_LOOKUP, kmax, 3'd3, '0, 1'b0, 1'b0);
    send_word(FUNC_LOOKUP, kmax, 3'd7, '0, 1'b0, 1'b0);
    // deeper than four: stored but never hit
    send_word(FUNC_STORE, kmax, 3'd7, 32'd5, 1'b0, 1'b1);
    send_word(FUNC_LOOKUP, kmax, 3'd7, '0, 1'b0, 1'b0);
    send_word(FUNC_LOOKUP, kmax, 3'd5, '0, 1'b0, 1'b0);
    // shallower, smaller bound: kept; then larger bound: replaced
    send_word(FUNC_STORE, kmax, 3'd2, 32'd3, 1'b1, 1'b1);
    send_word(FUNC_STORE, kmax, 3'd2, 32'd9, 1'b1, 1'b1);
    send_word(FUNC_LOOKUP, kmax, 3'd2, '0, 1'b0, 1'b0);
    // incomplete entry misses
    send_word(FUNC_STORE, '0, 3'd1, 32'd7, 1'b1, 1'b0);
    send_word(FUNC_LOOKUP, '0, 3'd1, '0, 1'b0, 1'b0);
    krival = rival_key('0);
    send_word(FUNC_LOOKUP, krival, 3'd1, '0, 1'b0, 1'b0);
    send_word(FUNC_LOOKUP, krival, 3'd6, '0, 1'b0, 1'b0);
    send_word(FUNC_STORE, krival, 3'd1, 32'h8000_0000, 1'b0, 1'b1);
    send_word(FUNC_LOOKUP, krival, 3'd1, '0, 1'b0, 1'b0);
    send_word(FUNC_LOOKUP, '0, 3'd1, '0, 1'b0, 1'b0);
    send_word(FUNC_STORE, '0, 3'd6, 32'h5555_aaaa, 1'b1, 1'b1);
  endtask

  task automatic test_random(int n);
    logic [KeyW-1:0] k;
    logic [DepthW-1:0] d;
    func_t f;
    for (int i = 0; i < n; i++) begin
      k = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, key_pool.size() - 1)]
                                     : rand_key();
      d = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 2)) : 3'($urandom_range(0, 7));
      f = $urandom_range(0, 1) ? FUNC_STORE : FUNC_LOOKUP;
      send_word(f, k, d, $urandom(), 1'($urandom()), $urandom_range(0, 9) < 8);
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    test_random(6);
  endtask

  task automatic test_drain_pause();
    in_ch.valid <= 1'b0;
    wait_drained();
    @(posedge clk);
    test_random(20);
  endtask

  initial begin
    logic [KeyW-1:0] k;
    failed = 1'b0;
    quiet = 1'b0;
    hold_cycles = 0;
    cycles = 0;
    fill_cnt = '0;
    coll_cnt = '0;
    disp_cnt = '0;
    foreach (depth_hits[i]) depth_hits[i] = '0;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_LOOKUP;
    in_ch.key_prefix = '0;
    in_ch.req_depth = '0;
    in_ch.entry_bound = '0;
    in_ch.entry_proof = 1'b0;
    in_ch.entry_complete = 1'b0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < 32; i++) begin
      k = rand_key();
      key_pool.insert(key_pool.size(), k);
      key_pool.insert(key_pool.size(), rival_key(k));
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(600);
    test_backpressure();
    test_drain_pause();
    quiet = 1'b1;
    test_random(300);
    quiet = 1'b0;
    test_random(1000);
    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (!failed && pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
